>>> hdl/irlcm_pkg.sv
// ----------------------------------------------------------------------------
// IR learning code matcher package
// Shared constants, event and class codes, and the types passed between the
// matcher modules.
// ----------------------------------------------------------------------------
package irlcm_pkg;

    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int REQ_W     = 2;
    localparam int CLS_W     = 2;
    localparam int LEARN_W   = 2;

    localparam int FRAME_EDGES_DEF = 33;

    // Edge positions, counted from zero, that carry the two code bytes.
    localparam int HIGH_FIRST = 2;
    localparam int HIGH_LAST  = 9;
    localparam int LOW_FIRST  = 18;
    localparam int LOW_LAST   = 25;

    // Window reset values in timer counts.
    localparam logic [DATA_W-1:0] SYNC_MIN_RST = 16'd3150;
    localparam logic [DATA_W-1:0] SYNC_MAX_RST = 16'd5850;
    localparam logic [DATA_W-1:0] ONE_MIN_RST  = 16'd1180;
    localparam logic [DATA_W-1:0] ONE_MAX_RST  = 16'd2200;
    localparam logic [DATA_W-1:0] ZERO_MIN_RST = 16'd394;
    localparam logic [DATA_W-1:0] ZERO_MAX_RST = 16'd732;

    localparam logic [DATA_W-1:0] ERASED_CODE = 16'hFFFF;
    localparam logic [BYTE_W-1:0] FORCED_BYTE = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 3'd5;

    // Event types.
    localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd3;

    // Interval classes.
    localparam logic [CLS_W-1:0] CLS_NONE = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ONE  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ZERO = 2'd2;
    localparam logic [CLS_W-1:0] CLS_SYNC = 2'd3;

    // Learn target codes.
    localparam logic [LEARN_W-1:0] LEARN_IDLE  = 2'd0;
    localparam logic [LEARN_W-1:0] LEARN_SLOT0 = 2'd1;
    localparam logic [LEARN_W-1:0] LEARN_SLOT1 = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] sync_min;
        logic [DATA_W-1:0] sync_max;
        logic [DATA_W-1:0] one_min;
        logic [DATA_W-1:0] one_max;
        logic [DATA_W-1:0] zero_min;
        logic [DATA_W-1:0] zero_max;
    } win_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] code;
    } frame_t;

endpackage

>>> hdl/irlcm_if.sv
// ----------------------------------------------------------------------------
// IR learning code matcher channels
// Valid/ready channels for the event stream and the result stream.
// ----------------------------------------------------------------------------
interface irlcm_req_if
    import irlcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] interval;
    logic              slot;

    modport source (output valid, output req_type, output interval, output slot,
                    input ready);
    modport sink (input valid, input req_type, input interval, input slot,
                  output ready);
endinterface

interface irlcm_res_if
    import irlcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              relay_one_on;
    logic              relay_two_on;
    logic              frame_done;
    logic [DATA_W-1:0] received_code;
    logic              learning_active;
    logic              code_learned;

    modport source (output valid, output relay_one_on, output relay_two_on,
                    output frame_done, output received_code,
                    output learning_active, output code_learned, input ready);
    modport sink (input valid, input relay_one_on, input relay_two_on,
                  input frame_done, input received_code,
                  input learning_active, input code_learned, output ready);
endinterface

>>> hdl/irlcm_classify.sv
// ----------------------------------------------------------------------------
// IR interval classifier
// Sorts one interval into the one, zero or sync window, in that order.
// ----------------------------------------------------------------------------
module irlcm_classify
    import irlcm_pkg::*;
(
    input  win_t              win,
    input  logic [DATA_W-1:0] interval,
    output logic [CLS_W-1:0]  cls
);

    always_comb
    begin
        priority if (interval >= win.one_min && interval <= win.one_max)
            cls = CLS_ONE;
        else if (interval >= win.zero_min && interval <= win.zero_max)
            cls = CLS_ZERO;
        else if (interval >= win.sync_min && interval <= win.sync_max)
            cls = CLS_SYNC;
        else
            cls = CLS_NONE;
    end

endmodule

>>> hdl/irlcm_frame.sv
// ----------------------------------------------------------------------------
// IR frame assembler
// Counts frame edges and shifts the classified bits into the two code bytes.
// ----------------------------------------------------------------------------
module irlcm_frame
    import irlcm_pkg::*;
#(
    parameter int FRAME_EDGES = FRAME_EDGES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [CLS_W-1:0] cls,
    output frame_t           frame
);

    localparam int CNT_W = $clog2(FRAME_EDGES + 1);
    localparam logic [CNT_W-1:0] LAST_EDGE = CNT_W'(FRAME_EDGES - 1);
    localparam logic [CNT_W-1:0] HF = CNT_W'(HIGH_FIRST);
    localparam logic [CNT_W-1:0] HL = CNT_W'(HIGH_LAST);
    localparam logic [CNT_W-1:0] LF = CNT_W'(LOW_FIRST);
    localparam logic [CNT_W-1:0] LL = CNT_W'(LOW_LAST);

    logic [CNT_W-1:0]  edge_count_reg, edge_count_next;
    logic [BYTE_W-1:0] high_acc_reg, high_acc_next;
    logic [BYTE_W-1:0] low_acc_reg, low_acc_next;
    logic              high_forced_reg, high_forced_next;
    logic              low_forced_reg, low_forced_next;

    logic              in_high, in_low, last;
    logic [BYTE_W-1:0] high_byte, low_byte;
    logic [BYTE_W-1:0] high_acc_upd, low_acc_upd;
    logic              high_forced_upd, low_forced_upd;

    assign in_high = (edge_count_reg >= HF) && (edge_count_reg <= HL);
    assign in_low  = (edge_count_reg >= LF) && (edge_count_reg <= LL);
    assign last    = (edge_count_reg == LAST_EDGE);

    // The bytes with the current edge shifted in.
    always_comb
    begin
        high_acc_upd    = high_acc_reg;
        low_acc_upd     = low_acc_reg;
        high_forced_upd = high_forced_reg;
        low_forced_upd  = low_forced_reg;
        if (in_high && !high_forced_reg)
        begin
            high_acc_upd    = {high_acc_reg[BYTE_W-2:0], cls == CLS_ONE};
            high_forced_upd = (cls == CLS_SYNC);
        end
        if (in_low && !low_forced_reg)
        begin
            low_acc_upd    = {low_acc_reg[BYTE_W-2:0], cls == CLS_ONE};
            low_forced_upd = (cls == CLS_SYNC);
        end
    end

    always_comb
    begin
        high_acc_next    = high_acc_reg;
        low_acc_next     = low_acc_reg;
        high_forced_next = high_forced_reg;
        low_forced_next  = low_forced_reg;
        edge_count_next  = edge_count_reg;
        if (step)
        begin
            high_acc_next    = high_acc_upd;
            low_acc_next     = low_acc_upd;
            high_forced_next = high_forced_upd;
            low_forced_next  = low_forced_upd;
            edge_count_next  = edge_count_reg + 1'b1;
            if (last)
            begin
                edge_count_next  = '0;
                high_acc_next    = '0;
                low_acc_next     = '0;
                high_forced_next = 1'b0;
                low_forced_next  = 1'b0;
            end
        end
    end

    // With a short frame the last edge can still carry a low byte bit, so the
    // code is taken from the bytes after this edge.
    assign high_byte  = high_forced_upd ? FORCED_BYTE : high_acc_upd;
    assign low_byte   = low_forced_upd ? FORCED_BYTE : low_acc_upd;
    assign frame.done = step && last;
    assign frame.code = {high_byte, low_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg  <= '0;
            high_acc_reg    <= '0;
            low_acc_reg     <= '0;
            high_forced_reg <= 1'b0;
            low_forced_reg  <= 1'b0;
        end
        else
        begin
            edge_count_reg  <= edge_count_next;
            high_acc_reg    <= high_acc_next;
            low_acc_reg     <= low_acc_next;
            high_forced_reg <= high_forced_next;
            low_forced_reg  <= low_forced_next;
        end
    end

endmodule

>>> hdl/ir_learning_code_matcher_core.sv
// ----------------------------------------------------------------------------
// IR learning code matcher core
// Decodes NEC-style IR frames from edge intervals, learns two codes and
// toggles two relays when a received code matches a learned one.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Moves
//   --------  ----------  ----------------------------------------------------
//   req       in          one event: edge interval, arm, toggle or erase
//   res       out         relay states and frame status after that event
//   cfg       in          write-only window registers (no handshake)
//
// Every event moves from its transfer on req into the input register, then
// through the decode logic into the result register, which drives res. A
// new event is taken every cycle as long as res drains; the rate is set by
// the single decode stage, which updates all state as the event advances.
// A stall on res holds the result register and then the input register, and
// req.ready drops only when both are full. Reset clears the frame, the learn
// slot and the relays, and sets both stored codes to the erased value.
//
module ir_learning_code_matcher_core
    import irlcm_pkg::*;
#(
    parameter int FRAME_EDGES = FRAME_EDGES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    irlcm_req_if.sink            req,
    irlcm_res_if.source          res
);

    // Window registers, for the user to write only while the block is idle; the block does not enforce it.
    win_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.sync_min <= SYNC_MIN_RST;
            win_reg.sync_max <= SYNC_MAX_RST;
            win_reg.one_min  <= ONE_MIN_RST;
            win_reg.one_max  <= ONE_MAX_RST;
            win_reg.zero_min <= ZERO_MIN_RST;
            win_reg.zero_max <= ZERO_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_MIN: win_reg.sync_min <= cfg_data;
                CFG_SYNC_MAX: win_reg.sync_max <= cfg_data;
                CFG_ONE_MIN:  win_reg.one_min  <= cfg_data;
                CFG_ONE_MAX:  win_reg.one_max  <= cfg_data;
                CFG_ZERO_MIN: win_reg.zero_min <= cfg_data;
                CFG_ZERO_MAX: win_reg.zero_max <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register stage.
    logic              in_valid_reg;
    logic [REQ_W-1:0]  in_type_reg;
    logic [DATA_W-1:0] in_interval_reg;
    logic              in_slot_reg;

    logic out_valid_reg;
    logic advance;

    // The decode stage moves whenever the result register is free or drains.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.valid && req.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg     <= req.req_type;
            in_interval_reg <= req.interval;
            in_slot_reg     <= req.slot;
        end
    end

    // Interval classing and frame assembly.
    logic [CLS_W-1:0] cls;
    frame_t           frame;
    logic             edge_step;

    assign edge_step = advance && (in_type_reg == REQ_EDGE);

    irlcm_classify u_classify (
        .win      (win_reg),
        .interval (in_interval_reg),
        .cls      (cls)
    );

    irlcm_frame #(
        .FRAME_EDGES (FRAME_EDGES)
    ) u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (edge_step),
        .cls   (cls),
        .frame (frame)
    );

    // Learn slot, stored codes and relays.
    logic [LEARN_W-1:0] learn_reg, learn_next;
    logic [DATA_W-1:0]  code0_reg, code0_next;
    logic [DATA_W-1:0]  code1_reg, code1_next;
    logic               relay0_reg, relay0_next;
    logic               relay1_reg, relay1_next;
    logic               learning, learned;

    assign learning = (learn_reg == LEARN_SLOT0) || (learn_reg == LEARN_SLOT1);

    always_comb
    begin
        learn_next  = learn_reg;
        code0_next  = code0_reg;
        code1_next  = code1_reg;
        relay0_next = relay0_reg;
        relay1_next = relay1_reg;
        learned     = 1'b0;
        if (advance)
        begin
            unique case (in_type_reg)
                REQ_EDGE:
                begin
                    if (frame.done)
                    begin
                        // A learned frame is stored and never compared.
                        if (learning)
                        begin
                            if (learn_reg == LEARN_SLOT0)
                                code0_next = frame.code;
                            else
                                code1_next = frame.code;
                            learn_next = LEARN_IDLE;
                            learned    = 1'b1;
                        end
                        else
                        begin
                            relay0_next = relay0_reg ^ (frame.code == code0_reg);
                            relay1_next = relay1_reg ^ (frame.code == code1_reg);
                        end
                    end
                end
                REQ_ARM:
                    learn_next = in_slot_reg ? LEARN_SLOT1 : LEARN_SLOT0;
                REQ_TOGGLE:
                begin
                    if (in_slot_reg)
                        relay1_next = !relay1_reg;
                    else
                        relay0_next = !relay0_reg;
                end
                REQ_ERASE:
                begin
                    code0_next = ERASED_CODE;
                    code1_next = ERASED_CODE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_reg  <= LEARN_IDLE;
            code0_reg  <= ERASED_CODE;
            code1_reg  <= ERASED_CODE;
            relay0_reg <= 1'b0;
            relay1_reg <= 1'b0;
        end
        else
        begin
            learn_reg  <= learn_next;
            code0_reg  <= code0_next;
            code1_reg  <= code1_next;
            relay0_reg <= relay0_next;
            relay1_reg <= relay1_next;
        end
    end

    // Result register. The payload is loaded with the state after the event.
    logic              out_relay0_reg, out_relay1_reg;
    logic              out_done_reg, out_learning_reg, out_learned_reg;
    logic [DATA_W-1:0] out_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_relay0_reg   <= relay0_next;
            out_relay1_reg   <= relay1_next;
            out_done_reg     <= frame.done;
            out_code_reg     <= frame.done ? frame.code : '0;
            out_learning_reg <= (learn_next == LEARN_SLOT0) ||
                                (learn_next == LEARN_SLOT1);
            out_learned_reg  <= learned;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.relay_one_on    = out_relay0_reg;
    assign res.relay_two_on    = out_relay1_reg;
    assign res.frame_done      = out_done_reg;
    assign res.received_code   = out_code_reg;
    assign res.learning_active = out_learning_reg;
    assign res.code_learned    = out_learned_reg;

endmodule
